/* rtl/wsf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsf_pkg
// shared constants and types of the wheel speed filter and setpoint ramp
// ----------------------------------------------------------------------------
package wsf_pkg;

    localparam int MOTORS = 4;
    localparam int MIDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_SPEED_PER_PULSE = 2'd0;
    localparam logic [1:0] REG_FILTER_GAIN     = 2'd1;
    localparam logic [1:0] REG_SLEW_LIMIT      = 2'd2;

    localparam logic [31:0] SPEED_PER_PULSE_RST = 32'd1306852;
    localparam logic [16:0] FILTER_GAIN_RST     = 17'd19661;
    localparam logic [15:0] SLEW_LIMIT_RST      = 16'd160;
    localparam logic [16:0] GAIN_ONE            = 17'd65536;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_RESYNC = 1'b1;

    typedef struct packed {
        logic [31:0] speed_per_pulse;
        logic [16:0] filter_gain;
        logic [15:0] slew_limit;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic delta;
        logic mul_lo;
        logic mul_hi;
        logic raw;
        logic filt_mul;
        logic filt_acc;
        logic filt_rnd;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic out_free;
    } status_t;

endpackage

/* rtl/wsf_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsf_cfg
// register file for gain, scale and ramp step behind a simple bus port
// ----------------------------------------------------------------------------
module wsf_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsf_pkg::ADDR_W-1:0]    paddr,
    input  logic [wsf_pkg::DATA_W-1:0]    pwdata,
    output logic [wsf_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output wsf_pkg::cfg_t                 cfg
);

    logic [31:0] speed_per_pulse_reg;
    logic [16:0] filter_gain_reg;
    logic [15:0] slew_limit_reg;
    logic [1:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_per_pulse_reg <= wsf_pkg::SPEED_PER_PULSE_RST;
            filter_gain_reg     <= wsf_pkg::FILTER_GAIN_RST;
            slew_limit_reg      <= wsf_pkg::SLEW_LIMIT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                wsf_pkg::REG_SPEED_PER_PULSE: speed_per_pulse_reg <= pwdata;
                wsf_pkg::REG_FILTER_GAIN:     filter_gain_reg     <= pwdata[16:0];
                wsf_pkg::REG_SLEW_LIMIT:      slew_limit_reg      <= pwdata[15:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            wsf_pkg::REG_SPEED_PER_PULSE: prdata = speed_per_pulse_reg;
            wsf_pkg::REG_FILTER_GAIN:     prdata = {15'b0, filter_gain_reg};
            wsf_pkg::REG_SLEW_LIMIT:      prdata = {16'b0, slew_limit_reg};
            default:                      prdata = '0;
        endcase
    end

    assign cfg.speed_per_pulse = speed_per_pulse_reg;
    assign cfg.filter_gain     = filter_gain_reg;
    assign cfg.slew_limit      = slew_limit_reg;

endmodule

/* rtl/wsf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsf_ctrl
// sequencer stepping one item through delta, product, raw and filter stages
// ----------------------------------------------------------------------------
module wsf_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  wsf_pkg::status_t  stat,
    output wsf_pkg::cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_RAW,
        ST_FILT_MUL,
        ST_FILT_ACC,
        ST_FILT_RND,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_axis_tvalid) state_next = ST_DELTA;
            ST_DELTA:    state_next = stat.skip ? ST_DONE : ST_MUL_LO;
            ST_MUL_LO:   state_next = ST_MUL_HI;
            ST_MUL_HI:   state_next = ST_RAW;
            ST_RAW:      state_next = ST_FILT_MUL;
            ST_FILT_MUL: state_next = ST_FILT_ACC;
            ST_FILT_ACC: state_next = ST_FILT_RND;
            ST_FILT_RND: state_next = ST_DONE;
            ST_DONE:     if (stat.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd          = '0;
        cmd.capture  = (state_reg == ST_IDLE) && s_axis_tvalid;
        cmd.delta    = (state_reg == ST_DELTA);
        cmd.mul_lo   = (state_reg == ST_MUL_LO);
        cmd.mul_hi   = (state_reg == ST_MUL_HI);
        cmd.raw      = (state_reg == ST_RAW);
        cmd.filt_mul = (state_reg == ST_FILT_MUL);
        cmd.filt_acc = (state_reg == ST_FILT_ACC);
        cmd.filt_rnd = (state_reg == ST_FILT_RND);
        cmd.commit   = (state_reg == ST_DONE) && stat.out_free;
    end

endmodule

/* rtl/wsf_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsf_dpath
// per-wheel state, ramp, scaled encoder delta, moving average, result register
// ----------------------------------------------------------------------------
module wsf_dpath
(
    input  logic              clk,
    input  logic              rst_n,
    input  wsf_pkg::cfg_t     cfg,
    input  wsf_pkg::cmd_t     cmd,
    output wsf_pkg::status_t  stat,
    input  logic [63:0]       s_axis_tdata,
    input  logic              s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [79:0]       m_axis_tdata
);

    logic [31:0]        last_count_reg [wsf_pkg::MOTORS];
    logic signed [23:0] smoothed_reg   [wsf_pkg::MOTORS];
    logic signed [23:0] ramp_reg       [wsf_pkg::MOTORS];

    logic                      op_reg;
    logic [1:0]                motor_reg;
    logic [31:0]               count_reg;
    logic signed [23:0]        target_reg;
    logic                      skip_reg;

    logic                      neg_reg;
    logic [31:0]               mag_reg;
    logic signed [23:0]        ramp_new_reg;
    logic [48:0]               pp_lo_reg;
    logic [47:0]               pp_hi_reg;
    logic signed [23:0]        raw_reg;
    logic signed [41:0]        fprod_reg;
    logic signed [41:0]        acc_reg;
    logic signed [23:0]        filt_reg;

    logic                      out_valid_reg;
    logic [79:0]               out_data_reg;

    logic [wsf_pkg::MIDX_W-1:0] idx;
    logic                       served;
    logic                       skip_now;
    logic signed [23:0]         ramp_cur;
    logic signed [23:0]         smooth_cur;
    logic [31:0]                delta;
    logic [31:0]                mag_next;
    logic signed [25:0]         ramp_up;
    logic signed [25:0]         ramp_dn;
    logic signed [25:0]         target_x;
    logic signed [23:0]         ramp_new_next;
    logic [48:0]                pp_lo_next;
    logic [47:0]                pp_hi_next;
    logic [64:0]                prod_sum;
    logic [52:0]                rmag;
    logic signed [23:0]         raw_next;
    logic [16:0]                alpha;
    logic signed [24:0]         fdiff;
    logic signed [41:0]         fprod_next;
    logic signed [41:0]         acc_next;
    logic signed [41:0]         rnd_bias;
    logic signed [41:0]         rnd_sum;

    assign idx        = wsf_pkg::MIDX_W'(motor_reg);
    assign served     = (32'(motor_reg) < wsf_pkg::MOTORS);
    assign skip_now   = (op_reg == wsf_pkg::OP_RESYNC) || !served;
    assign ramp_cur   = ramp_reg[idx];
    assign smooth_cur = smoothed_reg[idx];

    // wrapped delta as sign and magnitude
    assign delta    = count_reg - last_count_reg[idx];
    assign mag_next = delta[31] ? (32'd0 - delta) : delta;

    // slew-limited setpoint
    assign ramp_up  = 26'(ramp_cur) + 26'($signed({10'b0, cfg.slew_limit}));
    assign ramp_dn  = 26'(ramp_cur) - 26'($signed({10'b0, cfg.slew_limit}));
    assign target_x = 26'(target_reg);

    always_comb
    begin
        priority if (ramp_cur < target_reg)
            ramp_new_next = (ramp_up > target_x) ? target_reg : ramp_up[23:0];
        else if (ramp_cur > target_reg)
            ramp_new_next = (ramp_dn < target_x) ? target_reg : ramp_dn[23:0];
        else
            ramp_new_next = ramp_cur;
    end

    // 32x32 product in two 32x16 halves, rounding offset folded into the low half
    assign pp_lo_next = 49'(48'(mag_reg) * 48'(cfg.speed_per_pulse[15:0])) + 49'd2048;
    assign pp_hi_next = 48'(mag_reg) * 48'(cfg.speed_per_pulse[31:16]);
    assign prod_sum   = 65'(pp_lo_reg) + {1'b0, pp_hi_reg, 16'b0};
    assign rmag       = prod_sum[64:12];

    always_comb
    begin
        priority if (!neg_reg)
            raw_next = (rmag > 53'd8388607) ? 24'sh7FFFFF : $signed(rmag[23:0]);
        else if (rmag > 53'd8388608)
            raw_next = 24'sh800000;
        else
            raw_next = $signed(24'd0 - rmag[23:0]);
    end

    // moving average: old + alpha * (raw - old), all scaled by 2^16
    assign alpha      = (cfg.filter_gain > wsf_pkg::GAIN_ONE) ? wsf_pkg::GAIN_ONE
                                                              : cfg.filter_gain;
    assign fdiff      = 25'(raw_reg) - 25'(smooth_cur);
    assign fprod_next = 42'($signed({1'b0, alpha})) * 42'(fdiff);
    assign acc_next   = $signed({{2{smooth_cur[23]}}, smooth_cur, 16'b0}) + fprod_reg;
    assign rnd_bias   = acc_reg[41] ? 42'sd32767 : 42'sd32768;
    assign rnd_sum    = acc_reg + rnd_bias;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= s_axis_tuser;
            motor_reg  <= s_axis_tdata[1:0];
            count_reg  <= s_axis_tdata[33:2];
            target_reg <= $signed(s_axis_tdata[57:34]);
        end
        if (cmd.delta)
        begin
            neg_reg      <= delta[31];
            mag_reg      <= mag_next;
            ramp_new_reg <= ramp_new_next;
        end
        if (cmd.mul_lo)
            pp_lo_reg <= pp_lo_next;
        if (cmd.mul_hi)
            pp_hi_reg <= pp_hi_next;
        if (cmd.raw)
            raw_reg <= raw_next;
        if (cmd.filt_mul)
            fprod_reg <= fprod_next;
        if (cmd.filt_acc)
            acc_reg <= acc_next;
        if (cmd.filt_rnd)
            filt_reg <= rnd_sum[39:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg <= 1'b0;
        end
        else if (cmd.delta)
        begin
            skip_reg <= skip_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < wsf_pkg::MOTORS; i++)
            begin
                last_count_reg[i] <= '0;
                smoothed_reg[i]   <= '0;
                ramp_reg[i]       <= '0;
            end
        end
        else if (cmd.commit && served)
        begin
            last_count_reg[idx] <= count_reg;
            if (op_reg == wsf_pkg::OP_RESYNC)
            begin
                smoothed_reg[idx] <= '0;
                ramp_reg[idx]     <= '0;
            end
            else
            begin
                smoothed_reg[idx] <= filt_reg;
                ramp_reg[idx]     <= ramp_new_reg;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (skip_reg)
                out_data_reg <= {6'b0, 72'b0, motor_reg};
            else
                out_data_reg <= {6'b0, filt_reg, raw_reg, ramp_new_reg, motor_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign stat.skip     = skip_now;
    assign stat.out_free = !out_valid_reg || m_axis_tready;

`ifndef SYNTHESIS
    logic signed [25:0] ramp_dev;
    logic signed [25:0] step_x;

    assign ramp_dev = 26'(ramp_new_reg) - 26'(ramp_cur);
    assign step_x   = 26'($signed({10'b0, cfg.slew_limit}));

    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_axis_tvalid)
        else $error("committed item did not reach the result register");

    a_skip_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && skip_reg |=> m_axis_tdata[73:2] == 72'b0)
        else $error("resync or unserved wheel reported non-zero speeds");

    a_ramp_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && !skip_reg |-> (ramp_dev <= step_x) && (ramp_dev >= -step_x))
        else $error("setpoint moved by more than one ramp step");

    a_no_commit_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !cmd.commit)
        else $error("result overwritten while still waiting");
`endif

endmodule

/* rtl/wheel_speed_filter_and_ramp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_speed_filter_and_ramp
// multi-wheel encoder speed with moving-average filter and setpoint slew limit
//
// channel   direction  transfer                 payload
// s_axis    in         tvalid & tready          tdata: motor, encoder_count,
//                                               target_speed; tuser: op
// m_axis    out        tvalid & tready          tdata: motor_out, ramped_setpoint,
//                                               raw_speed, filtered_speed
// apb       in         psel/penable/pwrite      speed_per_pulse, filter_gain,
//                                               slew_limit at 0x0, 0x4, 0x8
//
// a control tick presents its result after these steps in order: delta and ramp,
// the 32x32 scale product as two 32x16 passes, saturation, then three filter steps
// a resync or an unserved wheel goes from the delta step straight to its result
// the next item is taken the cycle after the result is loaded
// a stalled output holds the sequencer in its final step until the register frees
// reset returns registers to their defaults and clears all wheel state at once
// ----------------------------------------------------------------------------
module wheel_speed_filter_and_ramp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [63:0]                   s_axis_tdata,  // motor, encoder_count, target_speed
    input  logic                          s_axis_tuser,  // op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [79:0]                   m_axis_tdata,  // motor_out, ramped_setpoint,
                                                         // raw_speed, filtered_speed
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsf_pkg::ADDR_W-1:0]    paddr,
    input  logic [wsf_pkg::DATA_W-1:0]    pwdata,
    output logic [wsf_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    wsf_pkg::cfg_t    cfg;
    wsf_pkg::cmd_t    cmd;
    wsf_pkg::status_t stat;

    wsf_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wsf_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    wsf_dpath u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
